@@ src/button_debounce_click_classifier_unit_assert.svh @@
// assertion macros for the button debounce click classifier
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BDC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdc assertion failed");

// next-cycle implication, disabled during reset
`define BDC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdc assertion failed");

`endif

@@ src/bdc_pkg.sv @@
// shared types, constants and helpers for the button debounce click classifier
package bdc_pkg;

  localparam int CountWidth = 16;
  localparam int CfgWidth   = 16;
  localparam int CmpWidth   = (CountWidth > CfgWidth) ? CountWidth : CfgWidth;

  localparam logic [CmpWidth-1:0] MinClickTicks = CmpWidth'(50);
  localparam logic [1:0]          TripleClicks  = 2'd3;

  typedef logic [CountWidth-1:0] count_t;
  typedef logic [CfgWidth-1:0]   cfg_word_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_TRIPLE = 3'd3,
    EV_LONG   = 3'd4
  } event_t;

  typedef enum logic [1:0] {
    REG_ACTIVE_LOW = 2'd0,
    REG_DEBOUNCE   = 2'd1,
    REG_LONG_PRESS = 2'd2,
    REG_CLICK_GAP  = 2'd3
  } reg_index_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + CountWidth'(1);
  endfunction

  function automatic logic [CmpWidth-1:0] cnt_ext(input count_t v);
    return CmpWidth'(v);
  endfunction

  function automatic logic [CmpWidth-1:0] cfg_ext(input cfg_word_t v);
    return CmpWidth'(v);
  endfunction

endpackage

@@ src/button_debounce_click_classifier_unit.sv @@
// button debouncer with single, double, triple click and long press events
//
//   channel   signals                                    beat
//   sample    sample_valid / sample_ready                raw_level
//   result    result_valid / result_ready                event_code, pressed
//   config    cfg_we, cfg_index, cfg_data                one register write
//
// one beat per cycle while the result side is not stalled: each sample runs through
// the counter and compare logic and lands in the result register.
// a new sample is taken whenever the result register is empty or being drained.
// rst is synchronous: config returns to its defaults and all counters clear.
// a stalled result holds the sample side until it is taken.
module button_debounce_click_classifier_unit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     sample_valid,
  output logic                     sample_ready,
  input  logic                     raw_level,
  output logic                     result_valid,
  input  logic                     result_ready,
  output logic [2:0]               event_code,
  output logic                     pressed,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [bdc_pkg::CfgWidth-1:0] cfg_data
);
  import bdc_pkg::*;

  logic      active_low;
  cfg_word_t debounce_ticks;
  cfg_word_t long_press_ticks;
  cfg_word_t click_gap_ticks;

  logic       last_raw, last_raw_next;
  count_t     settle_count, settle_count_next;
  logic       stable_pressed, stable_pressed_next;
  count_t     hold_count, hold_count_next;
  logic       long_fired, long_fired_next;
  logic [1:0] click_count, click_count_next;
  logic       click_pending, click_pending_next;
  count_t     gap_count, gap_count_next;
  event_t     ev_next;

  logic accept;
  logic raw_pressed;

  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;
  assign raw_pressed  = raw_level != active_low;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active_low       <= 1'b1;
      debounce_ticks   <= CfgWidth'(50);
      long_press_ticks <= CfgWidth'(1000);
      click_gap_ticks  <= CfgWidth'(300);
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ACTIVE_LOW: active_low       <= cfg_data[0];
        REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        REG_LONG_PRESS: long_press_ticks <= cfg_data;
        REG_CLICK_GAP:  click_gap_ticks  <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-sample update
  always_comb begin
    hold_count_next     = sat_inc(hold_count);
    gap_count_next      = sat_inc(gap_count);
    settle_count_next   = (raw_level != last_raw) ? '0 : sat_inc(settle_count);
    last_raw_next       = raw_level;
    stable_pressed_next = stable_pressed;
    long_fired_next     = long_fired;
    click_count_next    = click_count;
    click_pending_next  = click_pending;
    ev_next             = EV_NONE;

    if (cnt_ext(settle_count_next) > cfg_ext(debounce_ticks) &&
        raw_pressed != stable_pressed) begin
      stable_pressed_next = raw_pressed;
      if (raw_pressed) begin
        hold_count_next = '0;
        long_fired_next = 1'b0;
      end else if (!long_fired && cnt_ext(hold_count_next) > MinClickTicks) begin
        click_count_next   = click_count + 2'd1;
        gap_count_next     = '0;
        click_pending_next = 1'b1;
        if (click_count_next >= TripleClicks) begin
          ev_next            = EV_TRIPLE;
          click_count_next   = '0;
          click_pending_next = 1'b0;
        end
      end
    end

    if (stable_pressed_next && !long_fired_next &&
        cnt_ext(hold_count_next) >= cfg_ext(long_press_ticks)) begin
      long_fired_next    = 1'b1;
      ev_next            = EV_LONG;
      click_count_next   = '0;
      click_pending_next = 1'b0;
    end

    if (click_pending_next && !stable_pressed_next &&
        cnt_ext(gap_count_next) > cfg_ext(click_gap_ticks)) begin
      case (click_count_next)
        2'd1:    ev_next = EV_SINGLE;
        2'd2:    ev_next = EV_DOUBLE;
        default: ;
      endcase
      click_count_next   = '0;
      click_pending_next = 1'b0;
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw       <= 1'b1;
      settle_count   <= '0;
      stable_pressed <= 1'b0;
      hold_count     <= '0;
      long_fired     <= 1'b0;
      click_count    <= '0;
      click_pending  <= 1'b0;
      gap_count      <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (accept) begin
        last_raw       <= last_raw_next;
        settle_count   <= settle_count_next;
        stable_pressed <= stable_pressed_next;
        hold_count     <= hold_count_next;
        long_fired     <= long_fired_next;
        click_count    <= click_count_next;
        click_pending  <= click_pending_next;
        gap_count      <= gap_count_next;
        result_valid   <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code <= ev_next;
      pressed    <= stable_pressed_next;
    end
  end

endmodule

@@ src/bdc_checker.sv @@
// port-level checks for the button debounce click classifier, with bind
`include "button_debounce_click_classifier_unit_assert.svh"

module bdc_checker (
  input logic       clk,
  input logic       rst,
  input logic       sample_valid,
  input logic       sample_ready,
  input logic       result_valid,
  input logic       result_ready,
  input logic [2:0] event_code,
  input logic       pressed
);
  import bdc_pkg::*;

  logic       long_ev;
  logic       click_ev;
  logic       result_stall;
  logic [3:0] result_word;

  assign long_ev      = event_code == EV_LONG;
  assign click_ev     = (event_code == EV_SINGLE) || (event_code == EV_DOUBLE) ||
                        (event_code == EV_TRIPLE);
  assign result_stall = result_valid && !result_ready;
  assign result_word  = {event_code, pressed};

  // accepted beat shows up as a result
  `BDC_ASSERT_NEXT(a_beat_gives_result, clk, rst, sample_valid && sample_ready, result_valid)

  // long press only reported while held
  `BDC_ASSERT_NOW(a_long_while_pressed, clk, rst, result_valid && long_ev, pressed)

  // click events only reported after release
  `BDC_ASSERT_NOW(a_click_while_released, clk, rst, result_valid && click_ev, !pressed)

  // stalled result holds
  `BDC_ASSERT_NEXT(a_result_holds, clk, rst, result_stall, result_valid && $stable(result_word))

endmodule

bind button_debounce_click_classifier_unit bdc_checker u_bdc_checker (.*);

@@ bench/testbench.sv @@
// testbench for the button debounce click classifier: directed and random pin traces
module testbench;
  import bdc_pkg::*;

  typedef struct packed {
    event_t ev;
    logic   pressed;
  } tick_result_t;

  localparam count_t     ClickMinHold = 16'd50;
  localparam logic [1:0] TripleCount  = 2'd3;
  localparam int         HoldOffLen   = 60;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       sample_valid = 1'b0;
  logic       sample_ready;
  logic       raw_level = 1'b0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  logic [2:0] event_code;
  logic       pressed;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  cfg_word_t  cfg_data = '0;

  // button model state
  logic       cfg_active_low;
  cfg_word_t  cfg_debounce;
  cfg_word_t  cfg_long_press;
  cfg_word_t  cfg_click_gap;
  logic       last_level;
  count_t     settle_cnt;
  logic       db_pressed;
  count_t     hold_cnt;
  logic       long_done;
  logic [1:0] click_cnt;
  logic       click_wait;
  count_t     gap_cnt;

  tick_result_t expected_q[$];
  int err_count = 0;
  int items_sent = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  button_debounce_click_classifier_unit u_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .raw_level    (raw_level),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .event_code   (event_code),
    .pressed      (pressed),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic count_t bump(input count_t v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic reset_model();
    cfg_active_low = 1'b1;
    cfg_debounce   = 16'd50;
    cfg_long_press = 16'd1000;
    cfg_click_gap  = 16'd300;
    last_level     = 1'b1;
    settle_cnt     = '0;
    db_pressed     = 1'b0;
    hold_cnt       = '0;
    long_done      = 1'b0;
    click_cnt      = '0;
    click_wait     = 1'b0;
    gap_cnt        = '0;
  endtask

  function automatic tick_result_t step_button(input logic raw);
    tick_result_t r;
    logic raw_pressed;
    raw_pressed = (raw == !cfg_active_low);
    r.ev = EV_NONE;
    hold_cnt = bump(hold_cnt);
    gap_cnt = bump(gap_cnt);
    settle_cnt = (raw != last_level) ? '0 : bump(settle_cnt);
    last_level = raw;
    if (settle_cnt > cfg_debounce && raw_pressed != db_pressed) begin
      db_pressed = raw_pressed;
      if (db_pressed) begin
        hold_cnt = '0;
        long_done = 1'b0;
      end else if (!long_done && hold_cnt > ClickMinHold) begin
        click_cnt = click_cnt + 2'd1;
        gap_cnt = '0;
        click_wait = 1'b1;
        if (click_cnt == TripleCount) begin
          r.ev = EV_TRIPLE;
          click_cnt = '0;
          click_wait = 1'b0;
        end
      end
    end
    if (db_pressed && !long_done && hold_cnt >= cfg_long_press) begin
      long_done = 1'b1;
      r.ev = EV_LONG;
      click_cnt = '0;
      click_wait = 1'b0;
    end
    if (click_wait && !db_pressed && gap_cnt > cfg_click_gap) begin
      if (click_cnt == 2'd1) r.ev = EV_SINGLE;
      else if (click_cnt == 2'd2) r.ev = EV_DOUBLE;
      click_cnt = '0;
      click_wait = 1'b0;
    end
    r.pressed = db_pressed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endtask

  always @(posedge clk) begin : check_results
    tick_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result beat", event_code, 0);
      end else begin
        want = expected_q.pop_front();
        if (event_code !== want.ev) report_mismatch("event_code", event_code, want.ev);
        if (pressed !== want.pressed) report_mismatch("pressed", pressed, want.pressed);
      end
    end
    if (!rst && sample_valid && sample_ready) begin
      expected_q.push_back(step_button(raw_level));
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  task automatic send_sample(input logic v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    raw_level <= v;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic al, input cfg_word_t db, input cfg_word_t lp,
                              input cfg_word_t gap);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_index <= REG_ACTIVE_LOW;
    cfg_data <= cfg_word_t'(al);
    @(posedge clk);
    cfg_active_low = al;
    cfg_index <= REG_DEBOUNCE;
    cfg_data <= db;
    @(posedge clk);
    cfg_debounce = db;
    cfg_index <= REG_LONG_PRESS;
    cfg_data <= lp;
    @(posedge clk);
    cfg_long_press = lp;
    cfg_index <= REG_CLICK_GAP;
    cfg_data <= gap;
    @(posedge clk);
    cfg_click_gap = gap;
    cfg_we <= 1'b0;
  endtask

  task automatic press_release(input int hold_ticks, input int gap_ticks);
    repeat (hold_ticks) send_sample(!cfg_active_low);
    repeat (gap_ticks) send_sample(cfg_active_low);
  endtask

  task automatic test_reset_defaults();
    repeat (60) send_sample(1'b0);
    repeat (60) send_sample(1'b1);
  endtask

  task automatic test_click_kinds();
    write_config(1'b1, 16'd1, 16'd80, 16'd8);
    press_release(55, 12);
    press_release(55, 3);
    press_release(55, 12);
    repeat (3) press_release(55, 3);
    press_release(30, 12);
    press_release(100, 12);
    press_release(55, 3);
    press_release(90, 12);
  endtask

  task automatic test_long_press_short_limits();
    write_config(1'b0, 16'd0, 16'd0, 16'd4);
    press_release(6, 6);
    write_config(1'b0, 16'd0, 16'd1, 16'd4);
    press_release(6, 6);
  endtask

  task automatic test_bounce();
    write_config(1'b1, 16'd4, 16'd300, 16'd10);
    for (int i = 0; i < 10; i++) send_sample(i[0]);
    press_release(3, 1);
    press_release(30, 2);
    press_release(40, 20);
  endtask

  task automatic test_polarity_swap();
    write_config(1'b0, 16'd2, 16'd400, 16'd6);
    press_release(20, 10);
    repeat (10) send_sample(1'b1);
    write_config(1'b1, 16'd2, 16'd400, 16'd6);
    repeat (10) send_sample(1'b1);
    press_release(20, 10);
  endtask

  task automatic test_gap_limits();
    write_config(1'b1, 16'd0, 16'd500, 16'd0);
    press_release(55, 4);
    write_config(1'b1, 16'd0, 16'd500, 16'hFFFF);
    press_release(55, 3);
    press_release(55, 3);
    press_release(55, 3);
    press_release(55, 10);
  endtask

  task automatic test_result_backpressure();
    write_config(1'b1, 16'd1, 16'd100, 16'd5);
    hold_req = 1'b1;
    repeat (2) press_release(20, 20);
  endtask

  task automatic test_random_traffic();
    int stop_at;
    int kind;
    int hold_len;
    cfg_word_t lp;
    cfg_word_t gap;
    for (int p = 0; p < 2; p++) begin
      if (p == 1) idle_on = 1'b0;
      case ($urandom_range(0, 3))
        0: lp = 16'd1;
        1: lp = 16'hFFFF;
        default: lp = cfg_word_t'($urandom_range(60, 250));
      endcase
      case ($urandom_range(0, 4))
        0: gap = 16'd0;
        1: gap = 16'hFFFF;
        default: gap = cfg_word_t'($urandom_range(5, 60));
      endcase
      write_config(1'($urandom_range(0, 1)), cfg_word_t'($urandom_range(0, 4)), lp, gap);
      stop_at = items_sent + 40;
      while (items_sent < stop_at) begin
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
          repeat ($urandom_range(1, 8)) send_sample(1'($urandom_range(0, 1)));
        end else begin
          repeat ($urandom_range(0, 3)) send_sample(1'($urandom_range(0, 1)));
          hold_len = (kind < 4) ? $urandom_range(44, 60) : $urandom_range(10, 160);
          press_release(hold_len, $urandom_range(1, 80));
        end
      end
    end
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_click_kinds();
    test_long_press_short_limits();
    test_bounce();
    test_polarity_swap();
    test_gap_limits();
    test_result_backpressure();
    test_random_traffic();
    wait_for_results();
    repeat (4) @(posedge clk);
    if (err_count == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
